@@ hw/rtl/aes128_block_encrypt_defines.svh @@
// Assertion macros for the AES-128 encrypt pipeline.
// Used by aes128_block_encrypt.sv; no other dependencies.
`ifndef AES128_BLOCK_ENCRYPT_DEFINES_SVH
`define AES128_BLOCK_ENCRYPT_DEFINES_SVH
`ifndef SYNTHESIS
`define AES_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define AES_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AES_ASSERT(label, clk, rst, prop, msg)
`define AES_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

@@ hw/rtl/aes128_pkg.sv @@
// Shared types, S-box and round helpers for the AES-128 encrypt pipeline.
// No dependencies.
package aes128_pkg;

   localparam int ROUNDS = 10;
   localparam int STAGES = ROUNDS + 1;

   localparam logic [1:0] CSR_KEY_HIGH = 2'd0;
   localparam logic [1:0] CSR_KEY_LOW  = 2'd1;

   typedef logic [127:0] block_type;

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] r;
      case (a)
         8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
         8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
         8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
         8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
         8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
         8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
         8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
         8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
         8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
         8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
         8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
         8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
         8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
         8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
         8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
         8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
         8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
         8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
         8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
         8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
         8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
         8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
         8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
         8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
         8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
         8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
         8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
         8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
         8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
         8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
         8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
         8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
         8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
         8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
         8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
         8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
         8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
         8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
         8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
         8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
         8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
         8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
         8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
         8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
         8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
         8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
         8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
         8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
         8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
         8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
         8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
         8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
         8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
         8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
         8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
         8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
         8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
         8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
         8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
         8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
         8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
         8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
         8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
         8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; default: r=8'h16;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   // Byte i of a block sits at bits [127-8i -: 8].
   function automatic block_type sub_shift(input block_type s);
      block_type t;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            t[127 - 8*(4*c + r) -: 8] = sbox(s[127 - 8*(4*((c + r) % 4) + r) -: 8]);
      return t;
   endfunction

   function automatic block_type mix_all(input block_type s);
      block_type t;
      logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
      for (int c = 0; c < 4; c++) begin
         a0 = s[127 - 32*c -: 8];
         a1 = s[119 - 32*c -: 8];
         a2 = s[111 - 32*c -: 8];
         a3 = s[103 - 32*c -: 8];
         d0 = xtime(a0); d1 = xtime(a1); d2 = xtime(a2); d3 = xtime(a3);
         t[127 - 32*c -: 8] = d0 ^ d1 ^ a1 ^ a2 ^ a3;
         t[119 - 32*c -: 8] = a0 ^ d1 ^ d2 ^ a2 ^ a3;
         t[111 - 32*c -: 8] = a0 ^ a1 ^ d2 ^ d3 ^ a3;
         t[103 - 32*c -: 8] = d0 ^ a0 ^ a1 ^ a2 ^ d3;
      end
      return t;
   endfunction

   // Next round key from the previous one and the round constant.
   function automatic block_type next_key(input block_type k, input logic [7:0] rc);
      logic [31:0] w0, w1, w2, w3, t;
      t  = k[31:0];
      t  = {sbox(t[23:16]), sbox(t[15:8]), sbox(t[7:0]), sbox(t[31:24])} ^ {rc, 24'h0};
      w0 = k[127:96] ^ t;
      w1 = k[95:64] ^ w0;
      w2 = k[63:32] ^ w1;
      w3 = k[31:0] ^ w2;
      return {w0, w1, w2, w3};
   endfunction

   function automatic logic [7:0] rcon(input int i);
      logic [7:0] r;
      r = 8'h01;
      for (int j = 0; j < 10; j++)
         if (j < i) r = xtime(r);
      return r;
   endfunction

endpackage

@@ hw/rtl/aes128_block_encrypt.sv @@
// AES-128 encrypt pipeline, top level.
// Depends on aes128_pkg and aes128_block_encrypt_defines.svh.
// Fully unrolled AES-128: one request enters per cycle and its ciphertext leaves
// after an initial AddRoundKey stage plus one register stage per round. The round
// keys come from a chain of eleven registers behind the key registers: a copy of
// the key, then one expansion step per register. The chain runs every cycle, so
// a key write reaches the last round key via the whole chain. The whole pipeline
// advances together whenever its output stage is free, so throughput is one
// block per clock. Write the key only while the pipeline is empty; the next
// request may be taken from the second clock edge after the write.
`include "aes128_block_encrypt_defines.svh"
module aes128_block_encrypt (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // plain_high [63:0], plain_low [127:64]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // cipher_high [63:0], cipher_low [127:64]
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [63:0]  csr_wdata
);

   localparam int N = aes128_pkg::STAGES;

   aes128_pkg::block_type key_ff, key_in;
   aes128_pkg::block_type rk_ff [N];
   logic [N-1:0] kv_ff;  // round key pipeline settle marks
   aes128_pkg::block_type st_ff [N];
   logic [N-1:0] vld_ff;
   logic adv;

   // Advance when the output stage is empty or being taken
   assign adv        = !vld_ff[N-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[N-1];
   assign rsp_tdata  = {st_ff[N-1][63:0], st_ff[N-1][127:64]};

   // Key register writes
   always_comb begin
      key_in = key_ff;
      if (csr_we) begin
         unique case (csr_index)
            aes128_pkg::CSR_KEY_HIGH: key_in[127:64] = csr_wdata;
            aes128_pkg::CSR_KEY_LOW:  key_in[63:0]   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
         kv_ff  <= '0;
      end else begin
         key_ff <= key_in;
         kv_ff  <= {kv_ff[N-2:0], 1'b1};
      end
   end

   // Expand round keys, one step per register after the first
   always_ff @(posedge clock) begin
      rk_ff[0] <= key_ff;
      for (int i = 1; i < N; i++)
         rk_ff[i] <= aes128_pkg::next_key(rk_ff[i-1], aes128_pkg::rcon(i-1));
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[N-2:0], req_tvalid};
      end
   end

   // Round datapath
   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff[0] <= {req_tdata[63:0], req_tdata[127:64]} ^ rk_ff[0];
         for (int i = 1; i < N - 1; i++)
            st_ff[i] <= aes128_pkg::mix_all(aes128_pkg::sub_shift(st_ff[i-1])) ^ rk_ff[i];
         st_ff[N-1] <= aes128_pkg::sub_shift(st_ff[N-2]) ^ rk_ff[N-1];
      end
   end

   `AES_ASSERT(a_out_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "result dropped")
   `AES_ASSERT(a_ready, clock, reset, !rsp_tvalid |-> req_tready, "stall with empty output")
   `AES_ASSERT(a_stall_hold, clock, reset, !adv |=> $stable(vld_ff), "pipeline moved in stall")
   `AES_ASSERT(a_keys_settled, clock, reset, rsp_tvalid && rsp_tready |-> kv_ff[N-1], "keys unsettled")

endmodule
